>>> hdl/rtch_pkg.sv
// Shared types, constants and the multiply-accumulate schedule of the ray/triangle hit unit.
// Used by every module of the block; no dependencies.
package rtch_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ID_BITS_DEF    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int DIST_BITS      = 31;
  localparam int BARY_BITS      = 17;
  localparam int CFG_IDX_BITS   = 3;
  localparam int OP_BITS        = 5;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Z    = 3'd5;

  // scalar slots of the dot products
  localparam logic [1:0] SC_DET = 2'd0;
  localparam logic [1:0] SC_NU  = 2'd1;
  localparam logic [1:0] SC_NV  = 2'd2;
  localparam logic [1:0] SC_NT  = 2'd3;

  localparam logic [OP_BITS-1:0] OP_CORE_LAST = 5'd23;
  localparam logic [OP_BITS-1:0] OP_PNT_FIRST = 5'd24;
  localparam logic [OP_BITS-1:0] OP_PNT_LAST  = 5'd26;

  typedef enum logic [2:0] {
    VEC_E1, VEC_E2, VEC_T, VEC_D, VEC_P, VEC_Q, VEC_S, VEC_X
  } vec_t;

  typedef enum logic [2:0] {
    JOB_T, JOB_U, JOB_V, JOB_PX, JOB_PY, JOB_PZ
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_SIGN, ST_CHECK, ST_DIV, ST_CMP, ST_UPDATE, ST_FINISH
  } state_t;

  typedef struct packed {
    vec_t       wv;
    logic [1:0] wc;
    vec_t       nv;
    logic [1:0] nc;
    logic       neg;
    logic       clr;
    logic       wr;
    vec_t       dv;
    logic [1:0] dc;
  } mac_op_t;

  typedef struct packed {
    logic               capture;
    logic               mac_start;
    logic [OP_BITS-1:0] op_idx;
    logic               sign_fix;
    logic               div_start;
    job_t               job;
    logic               update;
    logic               emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic div_done;
    logic ok;
    logic closer;
    logic last;
    logic out_block;
  } dp_status_t;

  function automatic mac_op_t mk_op(vec_t wv, logic [1:0] wc, vec_t nv, logic [1:0] nc,
                                    logic ng, logic cl, logic wr, vec_t dv, logic [1:0] dc);
    mac_op_t o;
    o.wv = wv; o.wc = wc; o.nv = nv; o.nc = nc;
    o.neg = ng; o.clr = cl; o.wr = wr; o.dv = dv; o.dc = dc;
    return o;
  endfunction

  // P = D x E2, Q = T x E1, det = E1.P, nu = T.P, nv = D.Q, nt = E2.Q, then nt * D
  function automatic mac_op_t mac_op(logic [OP_BITS-1:0] idx);
    mac_op_t o;
    o = mk_op(VEC_E1, 2'd0, VEC_E1, 2'd0, 1'b0, 1'b1, 1'b0, VEC_X, 2'd0);
    case (idx)
      5'd0:  o = mk_op(VEC_D, 2'd1, VEC_E2, 2'd2, 1'b0, 1'b1, 1'b0, VEC_P, 2'd0);
      5'd1:  o = mk_op(VEC_D, 2'd2, VEC_E2, 2'd1, 1'b1, 1'b0, 1'b1, VEC_P, 2'd0);
      5'd2:  o = mk_op(VEC_D, 2'd2, VEC_E2, 2'd0, 1'b0, 1'b1, 1'b0, VEC_P, 2'd1);
      5'd3:  o = mk_op(VEC_D, 2'd0, VEC_E2, 2'd2, 1'b1, 1'b0, 1'b1, VEC_P, 2'd1);
      5'd4:  o = mk_op(VEC_D, 2'd0, VEC_E2, 2'd1, 1'b0, 1'b1, 1'b0, VEC_P, 2'd2);
      5'd5:  o = mk_op(VEC_D, 2'd1, VEC_E2, 2'd0, 1'b1, 1'b0, 1'b1, VEC_P, 2'd2);
      5'd6:  o = mk_op(VEC_T, 2'd1, VEC_E1, 2'd2, 1'b0, 1'b1, 1'b0, VEC_Q, 2'd0);
      5'd7:  o = mk_op(VEC_T, 2'd2, VEC_E1, 2'd1, 1'b1, 1'b0, 1'b1, VEC_Q, 2'd0);
      5'd8:  o = mk_op(VEC_T, 2'd2, VEC_E1, 2'd0, 1'b0, 1'b1, 1'b0, VEC_Q, 2'd1);
      5'd9:  o = mk_op(VEC_T, 2'd0, VEC_E1, 2'd2, 1'b1, 1'b0, 1'b1, VEC_Q, 2'd1);
      5'd10: o = mk_op(VEC_T, 2'd0, VEC_E1, 2'd1, 1'b0, 1'b1, 1'b0, VEC_Q, 2'd2);
      5'd11: o = mk_op(VEC_T, 2'd1, VEC_E1, 2'd0, 1'b1, 1'b0, 1'b1, VEC_Q, 2'd2);
      5'd12: o = mk_op(VEC_P, 2'd0, VEC_E1, 2'd0, 1'b0, 1'b1, 1'b0, VEC_S, SC_DET);
      5'd13: o = mk_op(VEC_P, 2'd1, VEC_E1, 2'd1, 1'b0, 1'b0, 1'b0, VEC_S, SC_DET);
      5'd14: o = mk_op(VEC_P, 2'd2, VEC_E1, 2'd2, 1'b0, 1'b0, 1'b1, VEC_S, SC_DET);
      5'd15: o = mk_op(VEC_P, 2'd0, VEC_T, 2'd0, 1'b0, 1'b1, 1'b0, VEC_S, SC_NU);
      5'd16: o = mk_op(VEC_P, 2'd1, VEC_T, 2'd1, 1'b0, 1'b0, 1'b0, VEC_S, SC_NU);
      5'd17: o = mk_op(VEC_P, 2'd2, VEC_T, 2'd2, 1'b0, 1'b0, 1'b1, VEC_S, SC_NU);
      5'd18: o = mk_op(VEC_Q, 2'd0, VEC_D, 2'd0, 1'b0, 1'b1, 1'b0, VEC_S, SC_NV);
      5'd19: o = mk_op(VEC_Q, 2'd1, VEC_D, 2'd1, 1'b0, 1'b0, 1'b0, VEC_S, SC_NV);
      5'd20: o = mk_op(VEC_Q, 2'd2, VEC_D, 2'd2, 1'b0, 1'b0, 1'b1, VEC_S, SC_NV);
      5'd21: o = mk_op(VEC_Q, 2'd0, VEC_E2, 2'd0, 1'b0, 1'b1, 1'b0, VEC_S, SC_NT);
      5'd22: o = mk_op(VEC_Q, 2'd1, VEC_E2, 2'd1, 1'b0, 1'b0, 1'b0, VEC_S, SC_NT);
      5'd23: o = mk_op(VEC_Q, 2'd2, VEC_E2, 2'd2, 1'b0, 1'b0, 1'b1, VEC_S, SC_NT);
      5'd24: o = mk_op(VEC_S, SC_NT, VEC_D, 2'd0, 1'b0, 1'b1, 1'b1, VEC_X, 2'd0);
      5'd25: o = mk_op(VEC_S, SC_NT, VEC_D, 2'd1, 1'b0, 1'b1, 1'b1, VEC_X, 2'd1);
      5'd26: o = mk_op(VEC_S, SC_NT, VEC_D, 2'd2, 1'b0, 1'b1, 1'b1, VEC_X, 2'd2);
      default: o = mk_op(VEC_E1, 2'd0, VEC_E1, 2'd0, 1'b0, 1'b1, 1'b0, VEC_X, 2'd0);
    endcase
    return o;
  endfunction

endpackage

>>> hdl/rtch_mac.sv
// Bit-serial signed multiply-accumulate unit: one multiplier bit per cycle.
// Depends on rtch_pkg only for the house import.
module rtch_mac import rtch_pkg::*; #(
  parameter int WA = 102,
  parameter int WB = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  clr,
  input  logic                  neg,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] acc,
  output logic                  done
);

  localparam int AW   = WA + WB;
  localparam int CNTW = $clog2(WB + 1);
  localparam logic [CNTW-1:0] LASTC = CNTW'(WB - 1);

  logic signed [AW-1:0] acc_r, ash_r;
  logic [WB-1:0]        bsh_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r, neg_r, done_r;
  logic                 sub;

  assign sub = neg_r ^ (cnt_r == LASTC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LASTC) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ash_r <= AW'(a);
      bsh_r <= b;
      cnt_r <= '0;
      neg_r <= neg;
      if (clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      // top multiplier bit carries negative weight
      if (bsh_r[0]) begin
        acc_r <= sub ? acc_r - ash_r : acc_r + ash_r;
      end
      ash_r <= ash_r <<< 1;
      bsh_r <= bsh_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> hdl/rtch_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag for quotients too wide.
// Depends on rtch_pkg only for the house import.
module rtch_div import rtch_pkg::*; #(
  parameter int NUMW = 135,
  parameter int DENW = 102,
  parameter int QW   = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            ovf,
  output logic            done
);

  localparam int RW   = DENW + QW;
  localparam int CNTW = $clog2(QW + 1);
  localparam logic [CNTW-1:0] LASTC = CNTW'(QW - 1);

  logic [RW-1:0]   rem_r, ds_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r, ovf_r;
  logic            ge;

  assign ge = rem_r >= ds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LASTC) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= RW'(num);
      ds_r  <= RW'({den, {(QW-1){1'b0}}});
      q_r   <= '0;
      cnt_r <= '0;
      ovf_r <= (num >> QW) >= NUMW'(den);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      q_r   <= {q_r[QW-2:0], ge};
      ds_r  <= ds_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign q    = q_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

>>> hdl/rtch_dp.sv
// Datapath: ray registers, edge vectors, MAC and divider units, candidate, best record, output.
// Depends on rtch_pkg, rtch_mac and rtch_div.
module rtch_dp import rtch_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_cmd_t                     cmd,
  output dp_status_t                    status,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,
  input  logic signed [COORD_BITS-1:0]  vtx_a [3],
  input  logic signed [COORD_BITS-1:0]  vtx_b [3],
  input  logic signed [COORD_BITS-1:0]  vtx_c [3],
  input  logic [ID_BITS-1:0]            tri_id,
  input  logic                          tri_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit_found,
  output logic [ID_BITS-1:0]            out_hit_id,
  output logic [DIST_BITS-1:0]          out_hit_distance,
  output logic [BARY_BITS-1:0]          out_bary_u,
  output logic [BARY_BITS-1:0]          out_bary_v,
  output logic signed [COORD_BITS-1:0]  out_point [3]
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int XW   = 2 * DW + 1;
  localparam int NW   = XW + DW + 2;
  localparam int AW   = NW + DW;
  localparam int QW   = (CW + 1 > DIST_BITS) ? CW + 1 : DIST_BITS;
  localparam int SUMW = QW + 2;
  localparam logic signed [SUMW-1:0] PMAX = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] PMIN = ~PMAX;
  localparam logic [CW-1:0] PMAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] PMIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE_C  = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [DW-1:0] e1_r [3], e2_r [3], tv_r [3], dv_r [3];
  logic signed [XW-1:0] pv_r [3], qv_r [3];
  logic signed [NW-1:0] det_r, nu_r, nv_r, nt_r;
  logic signed [AW-1:0] prod_r [3];
  logic [ID_BITS-1:0]   id_r;
  logic                 last_r;

  logic [DIST_BITS-1:0] cand_t_r, best_t_r;
  logic [BARY_BITS-1:0] cand_u_r, cand_v_r, best_u_r, best_v_r;
  logic [CW-1:0]        cand_p_r [3], best_p_r [3];
  logic [ID_BITS-1:0]   best_id_r;
  logic                 have_hit_r;

  logic                 out_valid_r, out_hit_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic [DIST_BITS-1:0] out_t_r;
  logic [BARY_BITS-1:0] out_u_r, out_v_r;
  logic [CW-1:0]        out_p_r [3];

  mac_op_t              op;
  logic [1:0]           wc, nc, dc;
  logic signed [NW-1:0] mac_a;
  logic signed [DW-1:0] mac_b;
  logic signed [AW-1:0] mac_acc;
  logic                 mac_done;

  logic [AW-1:0]        div_num;
  logic [QW-1:0]        div_q;
  logic                 div_ovf, div_done;
  logic [1:0]           pidx;
  logic                 pneg;
  logic signed [SUMW-1:0] qs, ps;
  logic [CW-1:0]        pout;
  logic [DIST_BITS-1:0] tsat;
  logic signed [NW:0]   uv_sum;

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
      end
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= ONE_C;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: org_r[0] <= cfg_data;
        CFG_ORIGIN_Y: org_r[1] <= cfg_data;
        CFG_ORIGIN_Z: org_r[2] <= cfg_data;
        CFG_DIR_X:    dir_r[0] <= cfg_data;
        CFG_DIR_Y:    dir_r[1] <= cfg_data;
        CFG_DIR_Z:    dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge vectors at transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= DW'(vtx_b[i]) - DW'(vtx_a[i]);
        e2_r[i] <= DW'(vtx_c[i]) - DW'(vtx_a[i]);
        tv_r[i] <= DW'(org_r[i]) - DW'(vtx_a[i]);
        dv_r[i] <= DW'(dir_r[i]);
      end
      id_r   <= tri_id;
      last_r <= tri_last;
    end
  end

  // MAC operand select
  always_comb begin
    op = mac_op(cmd.op_idx);
    wc = (op.wc == 2'd3) ? 2'd0 : op.wc;
    nc = (op.nc == 2'd3) ? 2'd0 : op.nc;
    dc = (op.dc == 2'd3) ? 2'd0 : op.dc;
    unique case (op.nv)
      VEC_E1:  mac_b = e1_r[nc];
      VEC_E2:  mac_b = e2_r[nc];
      VEC_T:   mac_b = tv_r[nc];
      VEC_D:   mac_b = dv_r[nc];
      default: mac_b = '0;
    endcase
    unique case (op.wv)
      VEC_E1:  mac_a = NW'(e1_r[wc]);
      VEC_E2:  mac_a = NW'(e2_r[wc]);
      VEC_T:   mac_a = NW'(tv_r[wc]);
      VEC_D:   mac_a = NW'(dv_r[wc]);
      VEC_P:   mac_a = NW'(pv_r[wc]);
      VEC_Q:   mac_a = NW'(qv_r[wc]);
      VEC_S:   mac_a = nt_r;
      default: mac_a = '0;
    endcase
  end

  rtch_mac #(.WA(NW), .WB(DW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mac_start),
    .clr   (op.clr),
    .neg   (op.neg),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // product writeback and orientation fix
  always_ff @(posedge clk) begin
    if (mac_done && op.wr) begin
      unique case (op.dv)
        VEC_P: pv_r[dc] <= mac_acc[XW-1:0];
        VEC_Q: qv_r[dc] <= mac_acc[XW-1:0];
        VEC_S: begin
          unique case (op.dc)
            SC_DET: det_r <= mac_acc[NW-1:0];
            SC_NU:  nu_r  <= mac_acc[NW-1:0];
            SC_NV:  nv_r  <= mac_acc[NW-1:0];
            SC_NT:  nt_r  <= mac_acc[NW-1:0];
            default: ;
          endcase
        end
        VEC_X: prod_r[dc] <= mac_acc;
        default: ;
      endcase
    end else if (cmd.sign_fix && det_r[NW-1]) begin
      det_r <= -det_r;
      nu_r  <= -nu_r;
      nv_r  <= -nv_r;
      nt_r  <= -nt_r;
    end
  end

  // divider operands
  always_comb begin
    unique case (cmd.job)
      JOB_PY:  pidx = 2'd1;
      JOB_PZ:  pidx = 2'd2;
      default: pidx = 2'd0;
    endcase
    pneg = prod_r[pidx][AW-1];
    unique case (cmd.job)
      JOB_T:   div_num = AW'({nt_r, {FRAC_BITS{1'b0}}});
      JOB_U:   div_num = AW'({nu_r, {FRAC_BITS{1'b0}}});
      JOB_V:   div_num = AW'({nv_r, {FRAC_BITS{1'b0}}});
      default: div_num = pneg ? -prod_r[pidx] : prod_r[pidx];
    endcase
  end

  rtch_div #(.NUMW(AW), .DENW(NW), .QW(QW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .q     (div_q),
    .ovf   (div_ovf),
    .done  (div_done)
  );

  // quotient post-processing
  always_comb begin
    tsat = (div_ovf || div_q > QW'(DIST_MAX)) ? DIST_MAX : div_q[DIST_BITS-1:0];
    qs   = pneg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    ps   = SUMW'(org_r[pidx]) + qs;
    if (div_ovf) begin
      pout = pneg ? PMIN_C : PMAX_C;
    end else if (ps > PMAX) begin
      pout = PMAX_C;
    end else if (ps < PMIN) begin
      pout = PMIN_C;
    end else begin
      pout = ps[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.job)
        JOB_T:   cand_t_r <= tsat;
        JOB_U:   cand_u_r <= div_q[BARY_BITS-1:0];
        JOB_V:   cand_v_r <= div_q[BARY_BITS-1:0];
        default: cand_p_r[pidx] <= pout;
      endcase
    end
  end

  // best record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_hit_r <= 1'b0;
    end else if (cmd.update) begin
      have_hit_r <= 1'b1;
    end else if (cmd.emit) begin
      have_hit_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      best_t_r  <= cand_t_r;
      best_u_r  <= cand_u_r;
      best_v_r  <= cand_v_r;
      best_id_r <= id_r;
      for (int i = 0; i < 3; i++) begin
        best_p_r[i] <= cand_p_r[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r <= have_hit_r;
      out_id_r  <= have_hit_r ? best_id_r : '0;
      out_t_r   <= have_hit_r ? best_t_r : '0;
      out_u_r   <= have_hit_r ? best_u_r : '0;
      out_v_r   <= have_hit_r ? best_v_r : '0;
      for (int i = 0; i < 3; i++) begin
        out_p_r[i] <= have_hit_r ? best_p_r[i] : '0;
      end
    end
  end

  assign uv_sum = (NW+1)'(nu_r) + (NW+1)'(nv_r);

  always_comb begin
    status.mac_done  = mac_done;
    status.div_done  = div_done;
    status.ok        = (det_r != '0) && !nu_r[NW-1] && (nu_r <= det_r) && !nv_r[NW-1] &&
                       (uv_sum <= (NW+1)'(det_r)) && !nt_r[NW-1] && (nt_r != '0);
    status.closer    = !have_hit_r || (cand_t_r < best_t_r);
    status.last      = last_r;
    status.out_block = out_valid_r && !out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_hit_found    = out_hit_r;
  assign out_hit_id       = out_id_r;
  assign out_hit_distance = out_t_r;
  assign out_bary_u       = out_u_r;
  assign out_bary_v       = out_v_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_point[i] = out_p_r[i];
    end
  end

  ap_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result emitted over an untaken result");

  ap_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> status.ok)
    else $error("record updated from a rejected triangle");

  ap_update_closer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!have_hit_r || cand_t_r < best_t_r))
    else $error("record updated by a hit that is not nearer");

endmodule

>>> hdl/rtch_ctrl.sv
// Controller: sequences the MAC schedule, sign fix, tests, divisions, update and result.
// Depends on rtch_pkg.
module rtch_ctrl import rtch_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t             state_r, state_nxt;
  logic [OP_BITS-1:0] op_r, op_nxt;
  job_t               job_r, job_nxt;
  logic               launched_r, launched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      op_r       <= '0;
      job_r      <= JOB_T;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      job_r      <= job_nxt;
      launched_r <= launched_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    job_nxt      = job_r;
    launched_nxt = launched_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt    = ST_MAC;
          op_nxt       = '0;
          launched_nxt = 1'b0;
        end
      end
      ST_MAC: begin
        if (!launched_r) begin
          launched_nxt = 1'b1;
        end else if (status.mac_done) begin
          launched_nxt = 1'b0;
          if (op_r == OP_CORE_LAST) begin
            state_nxt = ST_SIGN;
          end else if (op_r == OP_PNT_LAST) begin
            state_nxt = ST_DIV;
            job_nxt   = JOB_PX;
          end else begin
            op_nxt = op_r + 1'b1;
          end
        end
      end
      ST_SIGN: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (status.ok) begin
          state_nxt = ST_DIV;
          job_nxt   = JOB_T;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (!launched_r) begin
          launched_nxt = 1'b1;
        end else if (status.div_done) begin
          launched_nxt = 1'b0;
          unique case (job_r)
            JOB_T:  state_nxt = ST_CMP;
            JOB_U:  job_nxt = JOB_V;
            JOB_V: begin
              state_nxt = ST_MAC;
              op_nxt    = OP_PNT_FIRST;
            end
            JOB_PX: job_nxt = JOB_PY;
            JOB_PY: job_nxt = JOB_PZ;
            default: state_nxt = ST_UPDATE;
          endcase
        end
      end
      ST_CMP: begin
        if (status.closer) begin
          state_nxt = ST_DIV;
          job_nxt   = JOB_U;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        // hold the last triangle until the output register has room
        if (!status.last || !status.out_block) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.capture   = (state_r == ST_IDLE) && in_valid;
    cmd.mac_start = (state_r == ST_MAC) && !launched_r;
    cmd.op_idx    = op_r;
    cmd.sign_fix  = (state_r == ST_SIGN);
    cmd.div_start = (state_r == ST_DIV) && !launched_r;
    cmd.job       = job_r;
    cmd.update    = (state_r == ST_UPDATE);
    cmd.emit      = (state_r == ST_FINISH) && status.last && !status.out_block;
  end

endmodule

>>> hdl/ray_triangle_closest_hit_unit.sv
// Ray/triangle nearest-hit unit (Moller-Trumbore test in exact integer arithmetic), top level.
// Depends on rtch_pkg, rtch_ctrl and rtch_dp.
//
// Write the ray origin and direction (signed Q16.16) through the cfg port while the unit is
// idle, then stream triangles; each triangle marked last yields one result with the nearest
// hit, and the record is cleared for the next ray. One triangle at a time is processed. All
// products run on a single bit-serial multiply-accumulate unit, one multiplier bit per cycle,
// and all quotients on a restoring divider, one quotient bit per cycle. The next triangle is
// taken while a finished result still waits in the output register; a last triangle is held
// until that register has room.
module ray_triangle_closest_hit_unit import rtch_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_c_z,
  input  logic [ID_BITS-1:0]           in_triangle_id,
  input  logic                         in_last_triangle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit_found,
  output logic [ID_BITS-1:0]           out_hit_id,
  output logic [DIST_BITS-1:0]         out_hit_distance,
  output logic [BARY_BITS-1:0]         out_bary_u,
  output logic [BARY_BITS-1:0]         out_bary_v,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic signed [COORD_BITS-1:0] out_point_z
);

  ctrl_cmd_t                    cmd;
  dp_status_t                   status;
  logic signed [COORD_BITS-1:0] vtx_a [3], vtx_b [3], vtx_c [3];
  logic signed [COORD_BITS-1:0] out_point [3];

  assign vtx_a[0] = in_vertex_a_x;
  assign vtx_a[1] = in_vertex_a_y;
  assign vtx_a[2] = in_vertex_a_z;
  assign vtx_b[0] = in_vertex_b_x;
  assign vtx_b[1] = in_vertex_b_y;
  assign vtx_b[2] = in_vertex_b_z;
  assign vtx_c[0] = in_vertex_c_x;
  assign vtx_c[1] = in_vertex_c_y;
  assign vtx_c[2] = in_vertex_c_z;

  rtch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rtch_dp #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .vtx_a            (vtx_a),
    .vtx_b            (vtx_b),
    .vtx_c            (vtx_c),
    .tri_id           (in_triangle_id),
    .tri_last         (in_last_triangle),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_hit_found    (out_hit_found),
    .out_hit_id       (out_hit_id),
    .out_hit_distance (out_hit_distance),
    .out_bary_u       (out_bary_u),
    .out_bary_v       (out_bary_v),
    .out_point        (out_point)
  );

  assign out_point_x = out_point[0];
  assign out_point_y = out_point[1];
  assign out_point_z = out_point[2];

endmodule

>>> dv/ray_triangle_closest_hit_unit_tb.sv
// Testbench for ray_triangle_closest_hit_unit: streams triangles under several ray settings and
// checks each nearest-hit result against a built-in exact-integer predictor.
// Depends on rtch_pkg and the RTL of the hit unit.
`timescale 1ns / 1ps

module ray_triangle_closest_hit_unit_tb import rtch_pkg::*;;

  localparam int  CW        = COORD_BITS_DEF;
  localparam int  IW        = ID_BITS_DEF;
  localparam int  DRAIN_CYC = 1400;
  localparam longint LIMIT  = 40000000;

  typedef logic signed [159:0] wint_t;

  typedef struct {
    logic signed [CW-1:0] v [9];
    logic [IW-1:0]        id;
    logic                 last;
  } tri_t;

  typedef struct {
    logic                 found;
    logic [IW-1:0]        id;
    logic [DIST_BITS-1:0] tdist;
    logic [BARY_BITS-1:0] u;
    logic [BARY_BITS-1:0] v;
    logic signed [CW-1:0] p [3];
  } hit_t;

  class hit_tracker;
    logic signed [CW-1:0] ray [6];
    logic                 have;
    logic [31:0]          best_t;
    hit_t                 best;
    hit_t                 expected_hits [$];
    int                   errors;

    function new();
      ray = '{0, 0, 0, 0, 0, 65536};
      errors = 0;
      clear_best();
    endfunction

    function void clear_best();
      have = 1'b0;
      best_t = '1;
      best.found = 1'b0; best.id = '0; best.tdist = '0; best.u = '0; best.v = '0;
      best.p = '{0, 0, 0};
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] val);
      if (idx <= CFG_DIR_Z) ray[idx] = val;
    endfunction

    function void note_triangle(tri_t tr);
      wint_t a [3], b [3], c [3], o [3], d [3], e1 [3], e2 [3], tv [3], pv [3], qv [3];
      wint_t det, nu, nv, nt, tq, pp, pmax, pmin, dmax;
      logic [31:0] tval;
      hit_t r;
      bit ok;
      pmax = 32'sh7FFFFFFF;
      pmin = -pmax - 1;
      dmax = 32'sh7FFFFFFF;
      for (int i = 0; i < 3; i++) begin
        a[i] = tr.v[i]; b[i] = tr.v[3+i]; c[i] = tr.v[6+i];
        o[i] = ray[i]; d[i] = ray[3+i];
        e1[i] = b[i] - a[i]; e2[i] = c[i] - a[i]; tv[i] = o[i] - a[i];
      end
      pv[0] = d[1]*e2[2] - d[2]*e2[1];
      pv[1] = d[2]*e2[0] - d[0]*e2[2];
      pv[2] = d[0]*e2[1] - d[1]*e2[0];
      qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
      qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
      qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
      det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
      nu  = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
      nv  = d[0]*qv[0] + d[1]*qv[1] + d[2]*qv[2];
      nt  = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
      if (det < 0) begin
        det = -det; nu = -nu; nv = -nv; nt = -nt;
      end
      ok = det != 0 && nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det && nt > 0;
      if (ok) begin
        tq = (nt <<< 16) / det;
        tval = (tq > dmax) ? 32'h7FFFFFFF : tq[31:0];
        if (tval < best_t) begin
          have = 1'b1;
          best_t = tval;
          best.id = tr.id;
          tq = (nu <<< 16) / det;
          best.u = tq[BARY_BITS-1:0];
          tq = (nv <<< 16) / det;
          best.v = tq[BARY_BITS-1:0];
          for (int i = 0; i < 3; i++) begin
            // signed division truncates toward zero
            pp = o[i] + (nt * d[i]) / det;
            if (pp > pmax) pp = pmax;
            if (pp < pmin) pp = pmin;
            best.p[i] = pp[CW-1:0];
          end
        end
      end
      if (tr.last) begin
        r.found = have;
        r.id    = have ? best.id : '0;
        r.tdist = have ? best_t[DIST_BITS-1:0] : '0;
        r.u     = have ? best.u : '0;
        r.v     = have ? best.v : '0;
        for (int i = 0; i < 3; i++) r.p[i] = have ? best.p[i] : '0;
        expected_hits = {expected_hits, r};
        clear_best();
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(hit_t got);
      hit_t w;
      if (expected_hits.size() == 0) begin
        report("unexpected result", 64'(got.id), 0);
        return;
      end
      w = expected_hits.pop_front();
      if (got.found !== w.found) report("hit_found", 64'(got.found), 64'(w.found));
      if (got.id !== w.id) report("hit_id", 64'(got.id), 64'(w.id));
      if (got.tdist !== w.tdist) report("hit_distance", 64'(got.tdist), 64'(w.tdist));
      if (got.u !== w.u) report("bary_u", 64'(got.u), 64'(w.u));
      if (got.v !== w.v) report("bary_v", 64'(got.v), 64'(w.v));
      for (int i = 0; i < 3; i++)
        if (got.p[i] !== w.p[i]) report($sformatf("point[%0d]", i), 64'(got.p[i]),
                                        64'(w.p[i]));
    endtask

    task finish_up();
      while (expected_hits.size() != 0) begin
        void'(expected_hits.pop_front());
        report("missing result", 0, 0);
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CW-1:0]           cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [CW-1:0]    vtx [9];
  logic [IW-1:0]           in_triangle_id;
  logic                    in_last_triangle;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_hit_found;
  logic [IW-1:0]           out_hit_id;
  logic [DIST_BITS-1:0]    out_hit_distance;
  logic [BARY_BITS-1:0]    out_bary_u;
  logic [BARY_BITS-1:0]    out_bary_v;
  logic signed [CW-1:0]    out_point_x;
  logic signed [CW-1:0]    out_point_y;
  logic signed [CW-1:0]    out_point_z;

  hit_tracker tracker = new();
  longint     cycles = 0;
  int         burst_left = 0;

  ray_triangle_closest_hit_unit i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .in_vertex_a_x(vtx[0]), .in_vertex_a_y(vtx[1]), .in_vertex_a_z(vtx[2]),
    .in_vertex_b_x(vtx[3]), .in_vertex_b_y(vtx[4]), .in_vertex_b_z(vtx[5]),
    .in_vertex_c_x(vtx[6]), .in_vertex_c_y(vtx[7]), .in_vertex_c_z(vtx[8]),
    .in_triangle_id, .in_last_triangle,
    .out_valid, .out_ready, .out_hit_found, .out_hit_id, .out_hit_distance,
    .out_bary_u, .out_bary_v, .out_point_x, .out_point_y, .out_point_z
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ray_triangle_closest_hit_unit_tb: done, errors");
      $finish;
    end
  end

  // sample both transfers at the rising edge
  always @(posedge clk) begin
    tri_t tr;
    hit_t h;
    if (rst_n && in_valid && in_ready) begin
      tr.v = vtx; tr.id = in_triangle_id; tr.last = in_last_triangle;
      tracker.note_triangle(tr);
    end
    if (rst_n && out_valid && out_ready) begin
      h.found = out_hit_found; h.id = out_hit_id; h.tdist = out_hit_distance;
      h.u = out_bary_u; h.v = out_bary_v;
      h.p[0] = out_point_x; h.p[1] = out_point_y; h.p[2] = out_point_z;
      tracker.check_result(h);
    end
  end

  // receiver: alternate ready and stall stretches, some long
  always @(negedge clk) begin
    int  left;
    bit  mode;
    if (left <= 0) begin
      mode = ~mode;
      if (mode) left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 40);
      else      left = $urandom_range(1, 60);
    end
    left--;
    out_ready <= mode;
  end

  function automatic logic signed [CW-1:0] srand(int unsigned range);
    return CW'(longint'($urandom_range(0, 2 * range)) - longint'(range));
  endfunction

  function automatic tri_t flat(int x0, int y0, int x1, int y1, int x2, int y2, int z,
                                logic [IW-1:0] id, logic last);
    tri_t t;
    t.v = '{x0 <<< 16, y0 <<< 16, z, x1 <<< 16, y1 <<< 16, z, x2 <<< 16, y2 <<< 16, z};
    t.id = id; t.last = last;
    return t;
  endfunction

  // triangle built around a point on the current ray, mostly a hit
  function automatic tri_t make_tri();
    tri_t   t;
    int     kind, uu, vv;
    longint tp, pt [3], e1 [3], e2 [3], av;
    kind = $urandom_range(0, 99);
    t.id = IW'($urandom);
    t.last = 1'b0;
    if (kind < 15) begin
      foreach (t.v[i]) t.v[i] = $urandom;
      return t;
    end
    tp = $urandom_range(1, 1 << 20);
    if (kind < 22) tp = -tp;
    uu = $urandom_range(0, 256);
    vv = $urandom_range(0, 256 - uu);
    if (kind < 32) begin
      uu = $urandom_range(0, 400);
      vv = $urandom_range(0, 400);
    end
    for (int i = 0; i < 3; i++) begin
      pt[i] = longint'(tracker.ray[i]) + ((longint'(tracker.ray[3+i]) * tp) >>> 16);
      e1[i] = srand(1 << 18);
      e2[i] = srand(1 << 18);
      av = pt[i] - (e1[i] * uu + e2[i] * vv) / 256;
      t.v[i] = CW'(av);
      t.v[3+i] = CW'(av + e1[i]);
      t.v[6+i] = CW'(av + e2[i]);
    end
    return t;
  endfunction

  task automatic send_tri(tri_t t);
    vtx = t.v;
    in_triangle_id = t.id;
    in_last_triangle = t.last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 1500) : $urandom_range(1, 20))
        @(negedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic set_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz);
    write_reg(CFG_ORIGIN_X, ox); write_reg(CFG_ORIGIN_Y, oy); write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx); write_reg(CFG_DIR_Y, dy); write_reg(CFG_DIR_Z, dz);
  endtask

  // hold until every result is back and the unit has finished any trailing triangle
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(int n);
    tri_t t;
    int   sent, gsize;
    sent = 0;
    while (sent < n) begin
      gsize = $urandom_range(1, 6);
      for (int j = 0; j < gsize && sent < n; j++) begin
        t = make_tri();
        t.last = (j == gsize - 1) || (sent == n - 1);
        if ($urandom_range(0, 19) == 0) t.last = ~t.last;
        if (sent == n - 1) t.last = 1'b1;
        send_tri(t);
        sent++;
      end
    end
  endtask

  initial begin
    tri_t t;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_triangle_id = '0; in_last_triangle = 1'b0;
    foreach (vtx[i]) vtx[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset ray: origin 0, direction +z
    send_tri(flat(-1, -1, 1, -1, 0, 1, 5 <<< 16, 16'd1, 1'b0));
    send_tri(flat(-1, -1, 1, -1, 0, 1, 3 <<< 16, 16'd2, 1'b0));
    send_tri(flat(-1, -1, 1, -1, 0, 1, 3 <<< 16, 16'd3, 1'b0));   // tie, earlier wins
    send_tri(flat(-1, -1, 1, -1, 0, 1, -(2 <<< 16), 16'd4, 1'b1)); // behind the origin
    send_tri(flat(1, 1, 1, 1, 1, 1, 4 <<< 16, 16'd5, 1'b1));       // zero determinant
    send_tri(flat(2, -1, 4, -1, 3, 1, 4 <<< 16, 16'd6, 1'b0));     // u out of range
    send_tri(flat(-3, -1, -1, -1, -1, 1, 4 <<< 16, 16'd7, 1'b1));  // u + v past one
    send_tri(flat(-1, -1, 0, 0, -1, 1, 2 <<< 16, 16'd8, 1'b1));    // hit on a vertex
    send_tri(flat(-1, 0, 1, 0, 0, 1, 6 <<< 16, 16'd9, 1'b1));      // hit on an edge
    send_tri(flat(-1, -1, 1, -1, 0, 1, 0, 16'd10, 1'b1));          // t of zero
    t.id = '1; t.last = 1'b1;
    foreach (t.v[i]) t.v[i] = 32'h7FFFFFFF;
    send_tri(t);
    t.id = '0;
    foreach (t.v[i]) t.v[i] = 32'h80000000;
    send_tri(t);
    t.id = 16'hAAAA;
    foreach (t.v[i]) t.v[i] = (i % 2) ? 32'h55555555 : 32'hAAAAAAAA;
    send_tri(t);
    t.id = 16'h5555;
    foreach (t.v[i]) t.v[i] = (i % 2) ? 32'hAAAAAAAA : 32'h55555555;
    send_tri(t);
    run_random(150);
    drain();

    // very short direction: t saturates
    set_ray(0, 0, 0, 0, 0, 1);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
    send_tri(flat(-1, -1, 1, -1, 0, 1, 32'h40000000, 16'h1234, 1'b1));
    run_random(100);
    drain();

    // very long direction: a hit closer than one step reports distance zero
    set_ray(0, 0, 0, 0, 0, 32'h40000000);
    send_tri(flat(-1, -1, 1, -1, 0, 1, 1, 16'h4321, 1'b1));
    run_random(100);
    drain();

    // extremes of every register
    set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    run_random(200);
    drain();

    set_ray(srand(1 << 20), srand(1 << 20), srand(1 << 20),
            srand(1 << 18), srand(1 << 18), srand(1 << 18));
    run_random(650);
    drain();

    set_ray(srand(1 << 24), srand(1 << 24), srand(1 << 24),
            srand(1 << 12), srand(1 << 12), srand(1 << 12));
    run_random(650);
    drain();

    tracker.finish_up();
    if (tracker.errors == 0) begin
      $display("ray_triangle_closest_hit_unit_tb: done, clean");
    end else begin
      $display("ray_triangle_closest_hit_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
